/* rtl/core/qrs_pfc_pkg.sv */
// Shared types, constants and helpers of the QRS preprocessing filter chain.
`timescale 1ns / 1ps

package qrs_pfc_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned IN_W      = 16;
    // Taps that are really read: the raw line up to x12, the low-pass line up to
    // the one that becomes lp32, the high-pass line up to the one that becomes h4.
    localparam int unsigned RAW_DEPTH = 12;
    localparam int unsigned LPL_DEPTH = 31;
    localparam int unsigned HPL_DEPTH = 3;
    // Quotient bits resolved by each divider cell but the last, which takes the bits left over.
    localparam int unsigned DIV_BITS  = 6;

    // Stage values that travel with an item down the back half of the chain.
    typedef struct packed {
        logic              neg;
        logic [DATA_W-1:0] sq;
        logic [DATA_W-1:0] sl;
        logic [DATA_W-1:0] hp;
        logic [DATA_W-1:0] lp;
    } t_carry;

    // Signed division by two to the power sh, rounding toward zero.
    function automatic logic [DATA_W-1:0] f_sdiv_pow2(input logic [DATA_W-1:0] v,
                                                       input int unsigned sh);
        logic [DATA_W-1:0] bias;
        logic [DATA_W-1:0] biased;
        bias   = (DATA_W'(1) << sh) - DATA_W'(1);
        biased = v[DATA_W-1] ? v + bias : v;
        return DATA_W'($signed(biased) >>> sh);
    endfunction

endpackage

/* rtl/core/qrs_pfc_tap_cell.sv */
// One tap of a delay line: a register that takes its neighbour's value on each shift.
`timescale 1ns / 1ps

module qrs_pfc_tap_cell #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

/* rtl/core/qrs_pfc_div_cell.sv */
// One cell of the window divider: a few restoring steps of division by a constant.
`timescale 1ns / 1ps

module qrs_pfc_div_cell #(
    parameter int unsigned MAG_W   = 37,
    parameter int unsigned REM_W   = 5,
    parameter int unsigned DIVISOR = 30,
    parameter int unsigned STEPS   = 6
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [REM_W-1:0]      i_rem,
    input  logic [MAG_W-1:0]      i_nq,
    input  qrs_pfc_pkg::t_carry   i_car,
    output logic [REM_W-1:0]      o_rem,
    output logic [MAG_W-1:0]      o_nq,
    output qrs_pfc_pkg::t_carry   o_car
);

    localparam logic [REM_W:0] DIV_C = (REM_W + 1)'(DIVISOR);

    logic [REM_W-1:0]    v_rem;
    logic [MAG_W-1:0]    v_nq;
    logic [REM_W-1:0]    r_rem;
    logic [MAG_W-1:0]    r_nq;
    qrs_pfc_pkg::t_carry r_car;

    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    always_comb begin : p_steps
        logic [REM_W:0] v_trial;
        v_rem = i_rem;
        v_nq  = i_nq;
        for (int s = 0; s < STEPS; s++) begin
            v_trial = {v_rem, v_nq[MAG_W-1]};
            v_nq    = {v_nq[MAG_W-2:0], 1'b0};
            if (v_trial >= DIV_C) begin
                v_trial  = v_trial - DIV_C;
                v_nq[0]  = 1'b1;
            end
            v_rem = v_trial[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= v_rem;
            r_nq  <= v_nq;
            r_car <= i_car;
        end
    end

    assign o_rem = r_rem;
    assign o_nq  = r_nq;
    assign o_car = r_car;

endmodule

/* rtl/core/qrs_preprocessing_filter_chain_unit.sv */
// Top level of the QRS preprocessing filter chain.
// Registered stages in order: low-pass, high-pass, slope numerator, slope, square, window
// sum, absolute value, the divider cells and the output register. Throughput: one sample
// per clock unless m_axis_tready stalls the output; the low-pass and high-pass recursions
// each close through one register, and the window divider is a row of pipelined cells.
// Synchronous active-low reset clears all delay lines, the window sum and the valid bits.
`timescale 1ns / 1ps

module qrs_preprocessing_filter_chain_unit #(
    parameter int unsigned WINDOW_LENGTH = 30,
    parameter int unsigned SAMPLE_WIDTH  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // sample[15:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // low_passed[31:0], high_passed[63:32], slope[95:64], squared[127:96],
    // integrated[159:128]
    output logic [159:0] m_axis_tdata
);

    localparam int unsigned DW         = qrs_pfc_pkg::DATA_W;
    localparam int unsigned SW         = SAMPLE_WIDTH;
    localparam int unsigned TN_W       = SW + 3;
    localparam int unsigned SUM_W      = DW + $clog2(WINDOW_LENGTH);
    localparam int unsigned MAG_W      = SUM_W;
    localparam int unsigned REM_W      = $clog2(WINDOW_LENGTH);
    localparam int unsigned DB         = qrs_pfc_pkg::DIV_BITS;
    localparam int unsigned N_DIV      = (MAG_W + DB - 1) / DB;
    localparam int unsigned LAST_STEPS = MAG_W - DB * (N_DIV - 1);

    localparam int unsigned S_LP   = 0;
    localparam int unsigned S_HP   = 1;
    localparam int unsigned S_NUM  = 2;
    localparam int unsigned S_SL   = 3;
    localparam int unsigned S_SQ   = 4;
    localparam int unsigned S_SUM  = 5;
    localparam int unsigned S_ABS  = 6;
    localparam int unsigned S_DIV0 = 7;
    localparam int unsigned NSTG   = S_DIV0 + N_DIV + 1;
    localparam int unsigned S_OUT  = NSTG - 1;

    localparam logic [MAG_W-1:0] Q_MAX = MAG_W'(1) << (DW - 1);

    // Handshake chain
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_rdy;
    logic [NSTG-1:0] w_up;
    logic [NSTG-1:0] w_ld;

    assign w_rdy[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
    assign w_up[0]       = s_axis_tvalid;

    for (genvar k = 0; k < NSTG - 1; k++) begin : g_rdy
        assign w_rdy[k]   = !r_vld[k] || w_rdy[k+1];
        assign w_up[k+1]  = r_vld[k];
    end

    assign w_ld = w_up & w_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (w_rdy & w_up) | (~w_rdy & r_vld);
        end
    end

    assign s_axis_tready = w_rdy[0];
    assign m_axis_tvalid = r_vld[S_OUT];

    // Input sample, sign taken from bit SAMPLE_WIDTH-1
    logic [SW-1:0] w_x;

    if (SW <= qrs_pfc_pkg::IN_W) begin : g_x_cut
        assign w_x = s_axis_tdata[SW-1:0];
    end else begin : g_x_pad
        assign w_x = {{(SW - qrs_pfc_pkg::IN_W){1'b0}}, s_axis_tdata};
    end

    // Delay lines
    logic [SW-1:0] w_raw [qrs_pfc_pkg::RAW_DEPTH];
    logic [DW-1:0] w_lpl [qrs_pfc_pkg::LPL_DEPTH];
    logic [DW-1:0] w_hpl [qrs_pfc_pkg::HPL_DEPTH];
    logic [DW-1:0] w_sql [WINDOW_LENGTH];

    logic [DW-1:0]    r_lp;
    logic [DW-1:0]    r_lp2;
    logic [DW-1:0]    r_hp;
    logic [DW-1:0]    r_hpre;
    logic [DW-1:0]    r_dpre;
    logic [SUM_W-1:0] r_sum;

    qrs_pfc_pkg::t_carry r_s5;

    for (genvar g = 0; g < qrs_pfc_pkg::RAW_DEPTH; g++) begin : g_raw
        if (g == 0) begin : g_head
            qrs_pfc_tap_cell #(.WIDTH(SW)) u_tap (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_ld[S_LP]),
                .i_d(w_x), .o_q(w_raw[g])
            );
        end else begin : g_body
            qrs_pfc_tap_cell #(.WIDTH(SW)) u_tap (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_ld[S_LP]),
                .i_d(w_raw[g-1]), .o_q(w_raw[g])
            );
        end
    end

    for (genvar g = 0; g < qrs_pfc_pkg::LPL_DEPTH; g++) begin : g_lpl
        if (g == 0) begin : g_head
            qrs_pfc_tap_cell #(.WIDTH(DW)) u_tap (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_ld[S_HP]),
                .i_d(r_lp), .o_q(w_lpl[g])
            );
        end else begin : g_body
            qrs_pfc_tap_cell #(.WIDTH(DW)) u_tap (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_ld[S_HP]),
                .i_d(w_lpl[g-1]), .o_q(w_lpl[g])
            );
        end
    end

    for (genvar g = 0; g < qrs_pfc_pkg::HPL_DEPTH; g++) begin : g_hpl
        if (g == 0) begin : g_head
            qrs_pfc_tap_cell #(.WIDTH(DW)) u_tap (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_ld[S_NUM]),
                .i_d(r_hp), .o_q(w_hpl[g])
            );
        end else begin : g_body
            qrs_pfc_tap_cell #(.WIDTH(DW)) u_tap (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_ld[S_NUM]),
                .i_d(w_hpl[g-1]), .o_q(w_hpl[g])
            );
        end
    end

    for (genvar g = 0; g < WINDOW_LENGTH; g++) begin : g_sql
        if (g == 0) begin : g_head
            qrs_pfc_tap_cell #(.WIDTH(DW)) u_tap (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_ld[S_SUM]),
                .i_d(r_s5.sq), .o_q(w_sql[g])
            );
        end else begin : g_body
            qrs_pfc_tap_cell #(.WIDTH(DW)) u_tap (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_ld[S_SUM]),
                .i_d(w_sql[g-1]), .o_q(w_sql[g])
            );
        end
    end

    // Low-pass: y = 2*y1 - y2 + (x - 2*x6 + x12)/32
    logic [TN_W-1:0] w_tn;
    logic [TN_W-1:0] w_tq;
    logic [DW-1:0]   w_t;
    logic [DW-1:0]   w_lp;

    assign w_tn = {{3{w_x[SW-1]}}, w_x}
                - {{2{w_raw[5][SW-1]}}, w_raw[5], 1'b0}
                + {{3{w_raw[11][SW-1]}}, w_raw[11]};
    assign w_tq = TN_W'($signed(w_tn + (w_tn[TN_W-1] ? TN_W'(31) : TN_W'(0))) >>> 5);
    assign w_t  = {{(DW - TN_W){w_tq[TN_W-1]}}, w_tq};
    assign w_lp = (r_lp << 1) - r_lp2 + w_t;

    // High-pass: the history part of the sum is prepared one sample ahead.
    logic [DW-1:0] w_hp;
    logic [DW-1:0] w_num;

    assign w_hp  = r_hp - qrs_pfc_pkg::f_sdiv_pow2(r_lp, 5) + r_hpre;
    assign w_num = (r_hp << 1) + r_dpre;

    // Window sum, kept exact
    logic [SUM_W-1:0] w_sum;

    assign w_sum = r_sum - {{(SUM_W - DW){w_sql[WINDOW_LENGTH-1][DW-1]}},
                            w_sql[WINDOW_LENGTH-1]}
                         + {{(SUM_W - DW){r_s5.sq[DW-1]}}, r_s5.sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp   <= '0;
            r_lp2  <= '0;
            r_hp   <= '0;
            r_hpre <= '0;
            r_dpre <= '0;
            r_sum  <= '0;
        end else begin
            if (w_ld[S_LP]) begin
                r_lp  <= w_lp;
                r_lp2 <= r_lp;
            end
            if (w_ld[S_HP]) begin
                r_hp   <= w_hp;
                r_hpre <= w_lpl[14] - w_lpl[15] + qrs_pfc_pkg::f_sdiv_pow2(w_lpl[30], 5);
            end
            if (w_ld[S_NUM]) begin
                r_dpre <= r_hp - w_hpl[1] - (w_hpl[2] << 1);
            end
            if (w_ld[S_SUM]) begin
                r_sum <= w_sum;
            end
        end
    end

    // Payload registers that travel with each item
    logic [DW-1:0]       r_s2_lp;
    logic [DW-1:0]       r_s3_lp;
    logic [DW-1:0]       r_s3_hp;
    logic [DW-1:0]       r_num;
    qrs_pfc_pkg::t_carry r_s4;
    qrs_pfc_pkg::t_carry r_s6;
    qrs_pfc_pkg::t_carry r_s7;
    logic [MAG_W-1:0]    r_mag;
    qrs_pfc_pkg::t_carry r_out;
    logic [DW-1:0]       r_ig;

    logic [REM_W-1:0]    w_rem [N_DIV+1];
    logic [MAG_W-1:0]    w_nq  [N_DIV+1];
    qrs_pfc_pkg::t_carry w_car [N_DIV+1];
    logic [DW-1:0]       w_prod;

    assign w_prod = r_s4.sl * r_s4.sl;

    always_ff @(posedge i_clk) begin
        if (w_ld[S_HP]) begin
            r_s2_lp <= r_lp;
        end
        if (w_ld[S_NUM]) begin
            r_s3_lp <= r_s2_lp;
            r_s3_hp <= r_hp;
            r_num   <= w_num;
        end
        if (w_ld[S_SL]) begin
            r_s4.lp  <= r_s3_lp;
            r_s4.hp  <= r_s3_hp;
            r_s4.sl  <= qrs_pfc_pkg::f_sdiv_pow2(r_num, 3);
            r_s4.sq  <= '0;
            r_s4.neg <= 1'b0;
        end
        if (w_ld[S_SQ]) begin
            r_s5 <= {r_s4.neg, w_prod, r_s4.sl, r_s4.hp, r_s4.lp};
        end
        if (w_ld[S_SUM]) begin
            r_s6 <= r_s5;
        end
        if (w_ld[S_ABS]) begin
            r_s7  <= {r_sum[SUM_W-1], r_s6.sq, r_s6.sl, r_s6.hp, r_s6.lp};
            r_mag <= r_sum[SUM_W-1] ? -r_sum : r_sum;
        end
        if (w_ld[S_OUT]) begin
            r_out <= w_car[N_DIV];
            r_ig  <= w_car[N_DIV].neg ? -w_nq[N_DIV][DW-1:0] : w_nq[N_DIV][DW-1:0];
        end
    end

    // Divider: a row of cells, each resolving a few quotient bits of |sum| / window
    assign w_rem[0] = '0;
    assign w_nq[0]  = r_mag;
    assign w_car[0] = r_s7;

    for (genvar d = 0; d < N_DIV; d++) begin : g_div
        qrs_pfc_div_cell #(
            .MAG_W  (MAG_W),
            .REM_W  (REM_W),
            .DIVISOR(WINDOW_LENGTH),
            .STEPS  ((d == N_DIV - 1) ? LAST_STEPS : DB)
        ) u_div (
            .i_clk(i_clk),
            .i_en (w_ld[S_DIV0 + d]),
            .i_rem(w_rem[d]),
            .i_nq (w_nq[d]),
            .i_car(w_car[d]),
            .o_rem(w_rem[d+1]),
            .o_nq (w_nq[d+1]),
            .o_car(w_car[d+1])
        );
    end

    assign m_axis_tdata = {r_ig, r_out.sq, r_out.sl, r_out.hp, r_out.lp};

    // A stalled input means every stage holds an item and the output is blocked.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> ((&r_vld) && !m_axis_tready))
        else $error("input stalled while the chain has room");

    // The window quotient must fit the 32-bit result before its sign is applied.
    a_quot_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld[S_OUT] |-> (w_nq[N_DIV] <= Q_MAX))
        else $error("window quotient out of range");

    // No result is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !m_axis_tvalid)
        else $error("result offered straight after reset");

endmodule
